// ===== rtl/core/tsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared widths, codes and control types of the two stage tensor contraction.
// ----------------------------------------------------------------------------
package tsc_pkg;

  // item field widths
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned INDEX_W   = 12;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned POT_W     = 32;
  localparam int unsigned OUT_IDX_W = 3;

  // bond dimension register
  localparam int unsigned          BOND_DIM_W   = 4;
  localparam logic [BOND_DIM_W-1:0] BOND_DIM_RST = 4'd8;

  // built maximum of the bond dimension
  localparam int unsigned DEF_MAX_BOND_DIM = 8;

  // arithmetic
  localparam int unsigned LR_W      = 32;
  localparam int unsigned PROD_W    = 48;
  localparam int unsigned T_SHIFT   = 30;
  localparam int unsigned OUT_SHIFT = 15;
  localparam logic signed [POT_W-1:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [POT_W-1:0] SAT_MIN = 32'sh8000_0000;

  // item commands
  typedef enum logic [CMD_W-1:0] {
    OP_WRITE_U     = 3'd0,
    OP_WRITE_V     = 3'd1,
    OP_WRITE_LEFT  = 3'd2,
    OP_WRITE_RIGHT = 3'd3,
    OP_START       = 3'd4
  } tsc_op_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STAGE1,
    ST_DRAIN,
    ST_STAGE2,
    ST_WAIT_OUT
  } tsc_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;      // input item taken this cycle
    logic issue;       // one multiply-accumulate step enters the pipe
    logic phase2;      // step belongs to the isometry stage
    logic first;       // first step of a sum
    logic last;        // last step of a sum
    logic final_item;  // current output position is the last one
  } ctrl_cmd_t;

  // flags that travel along the mac pipe
  typedef struct packed {
    logic vld;
    logic phase2;
    logic first;
    logic last;
  } pipe_t;

  // datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== rtl/core/tsc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_in_if
// Input channel: load and start items with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tsc_in_if;
  logic                                valid;
  logic                                ready;
  logic        [tsc_pkg::CMD_W-1:0]    cmd;
  logic        [tsc_pkg::INDEX_W-1:0]  index;
  logic signed [tsc_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output cmd, output index, output value, input ready);
  modport sink   (input valid, input cmd, input index, input value, output ready);
endinterface

// ===== rtl/core/tsc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_out_if
// Output channel: one potential item per output position.
// ----------------------------------------------------------------------------
interface tsc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tsc_pkg::POT_W-1:0]     potential;
  logic        [tsc_pkg::OUT_IDX_W-1:0] out_index;
  logic                                 last;

  modport source (output valid, output potential, output out_index, output last,
                  input ready);
  modport sink   (input valid, input potential, input out_index, input last,
                  output ready);
endinterface

// ===== rtl/core/tsc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_ctrl
// Sequencer: bond dimension register, loop counters and step commands.
// ----------------------------------------------------------------------------
module tsc_ctrl #(
  parameter int unsigned MAX_BOND_DIM = tsc_pkg::DEF_MAX_BOND_DIM,
  localparam int unsigned IDX_W  = (MAX_BOND_DIM > 1) ? $clog2(MAX_BOND_DIM) : 1,
  localparam int unsigned AB_W   = (MAX_BOND_DIM > 1) ? $clog2(MAX_BOND_DIM * MAX_BOND_DIM) : 1,
  localparam int unsigned CHI_W  = $clog2(MAX_BOND_DIM + 1),
  localparam int unsigned CHI2_W = $clog2(MAX_BOND_DIM * MAX_BOND_DIM + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tsc_pkg::BOND_DIM_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic [tsc_pkg::CMD_W-1:0]         in_cmd_i,
  output logic                              in_ready_o,
  input  tsc_pkg::dp_status_t               status_i,
  output tsc_pkg::ctrl_cmd_t                cmd_o,
  output logic [IDX_W-1:0]                  c_o,
  output logic [IDX_W-1:0]                  d_o,
  output logic [AB_W-1:0]                   ab_o,
  output logic [IDX_W-1:0]                  i_o,
  output logic [CHI_W-1:0]                  chi_o,
  output logic [CHI2_W-1:0]                 chi2_o
);
  import tsc_pkg::*;

  tsc_state_e              state_q, state_d;
  logic [BOND_DIM_W-1:0]   bond_dim_q;
  logic [CHI_W-1:0]        chi_q, chi_sel;
  logic [CHI2_W-1:0]       chi2_q;
  logic [IDX_W-1:0]        c_q, c_d, d_q, d_d, i_q, i_d;
  logic [AB_W-1:0]         ab_q, ab_d;
  logic [IDX_W-1:0]        chi_m1;
  logic [AB_W-1:0]         chi2_m1;
  logic                    c_last, d_last, ab_last, i_last;
  logic                    start_acc, drained;

  // clamp the register to the usable bond dimension
  always_comb begin
    if (bond_dim_q == '0) begin
      chi_sel = CHI_W'(1);
    end else if (32'(bond_dim_q) > MAX_BOND_DIM) begin
      chi_sel = CHI_W'(MAX_BOND_DIM);
    end else begin
      chi_sel = CHI_W'(bond_dim_q);
    end
  end

  // loop bounds
  assign chi_m1    = IDX_W'(chi_q - CHI_W'(1));
  assign chi2_m1   = AB_W'(chi2_q - CHI2_W'(1));
  assign c_last    = (c_q == chi_m1);
  assign d_last    = (d_q == chi_m1);
  assign ab_last   = (ab_q == chi2_m1);
  assign i_last    = (i_q == chi_m1);
  assign start_acc = in_valid_i && in_ready_o && (in_cmd_i == OP_START);
  assign drained   = !status_i.pipe_busy && !status_i.out_busy;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_acc) state_d = ST_STAGE1;
      end
      ST_STAGE1: begin
        if (c_last && d_last && ab_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) state_d = ST_STAGE2;
      end
      ST_STAGE2: begin
        if (ab_last) state_d = ST_WAIT_OUT;
      end
      ST_WAIT_OUT: begin
        if (drained) state_d = i_last ? ST_IDLE : ST_STAGE2;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // loop counters
  always_comb begin
    c_d  = c_q;
    d_d  = d_q;
    ab_d = ab_q;
    i_d  = i_q;
    case (state_q)
      ST_IDLE: begin
        c_d  = '0;
        d_d  = '0;
        ab_d = '0;
        i_d  = '0;
      end
      ST_STAGE1: begin
        d_d = d_last ? '0 : d_q + IDX_W'(1);
        if (d_last) begin
          c_d = c_last ? '0 : c_q + IDX_W'(1);
          if (c_last) ab_d = ab_last ? '0 : ab_q + AB_W'(1);
        end
      end
      ST_STAGE2: begin
        ab_d = ab_last ? '0 : ab_q + AB_W'(1);
      end
      ST_WAIT_OUT: begin
        if (drained && !i_last) i_d = i_q + IDX_W'(1);
      end
      default: begin
        c_d = c_q;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o            = '0;
    in_ready_o       = 1'b0;
    cmd_o.final_item = i_last;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_STAGE1: begin
        cmd_o.issue = 1'b1;
        cmd_o.first = (c_q == '0) && (d_q == '0);
        cmd_o.last  = c_last && d_last;
      end
      ST_STAGE2: begin
        cmd_o.issue  = 1'b1;
        cmd_o.phase2 = 1'b1;
        cmd_o.first  = (ab_q == '0);
        cmd_o.last   = ab_last;
      end
      default: begin
        cmd_o.issue = 1'b0;
      end
    endcase
  end

  assign c_o    = c_q;
  assign d_o    = d_q;
  assign ab_o   = ab_q;
  assign i_o    = i_q;
  assign chi_o  = chi_q;
  assign chi2_o = chi2_q;

  // state, counters and bond dimension
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      bond_dim_q <= BOND_DIM_RST;
      chi_q      <= CHI_W'(MAX_BOND_DIM);
      chi2_q     <= CHI2_W'(MAX_BOND_DIM * MAX_BOND_DIM);
      c_q        <= '0;
      d_q        <= '0;
      ab_q       <= '0;
      i_q        <= '0;
    end else begin
      state_q <= state_d;
      c_q     <= c_d;
      d_q     <= d_d;
      ab_q    <= ab_d;
      i_q     <= i_d;
      if (cfg_we_i) bond_dim_q <= cfg_wdata_i;
      if (start_acc) begin
        chi_q  <= chi_sel;
        chi2_q <= CHI2_W'(chi_sel) * CHI2_W'(chi_sel);
      end
    end
  end

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_acc |=> (state_q == ST_STAGE1))
    else $error("start item did not launch the first stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STAGE2) |-> !status_i.out_busy)
    else $error("isometry step issued while a result is still pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_q <= chi_m1) && (d_q <= chi_m1) && (i_q <= chi_m1))
    else $error("loop counter beyond bond dimension");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (ab_q == '0))
    else $error("element counter not cleared in idle");

endmodule

// ===== rtl/core/tsc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_datapath
// Tensor stores, address generation, shared multiply-accumulate pipe and
// output register.
// ----------------------------------------------------------------------------
module tsc_datapath #(
  parameter int unsigned MAX_BOND_DIM = tsc_pkg::DEF_MAX_BOND_DIM,
  localparam int unsigned IDX_W   = (MAX_BOND_DIM > 1) ? $clog2(MAX_BOND_DIM) : 1,
  localparam int unsigned AB_W    = (MAX_BOND_DIM > 1) ? $clog2(MAX_BOND_DIM * MAX_BOND_DIM) : 1,
  localparam int unsigned CHI_W   = $clog2(MAX_BOND_DIM + 1),
  localparam int unsigned CHI2_W  = $clog2(MAX_BOND_DIM * MAX_BOND_DIM + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic        [tsc_pkg::CMD_W-1:0]    in_cmd_i,
  input  logic        [tsc_pkg::INDEX_W-1:0]  in_index_i,
  input  logic signed [tsc_pkg::VALUE_W-1:0]  in_value_i,
  input  tsc_pkg::ctrl_cmd_t                  cmd_i,
  input  logic        [IDX_W-1:0]             c_i,
  input  logic        [IDX_W-1:0]             d_i,
  input  logic        [AB_W-1:0]              ab_i,
  input  logic        [IDX_W-1:0]             i_i,
  input  logic        [CHI_W-1:0]             chi_i,
  input  logic        [CHI2_W-1:0]            chi2_i,
  output tsc_pkg::dp_status_t                 status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [tsc_pkg::POT_W-1:0]    out_potential_o,
  output logic        [tsc_pkg::OUT_IDX_W-1:0] out_index_o,
  output logic                                out_last_o
);
  import tsc_pkg::*;

  localparam int unsigned U_TOTAL = MAX_BOND_DIM ** 4;
  localparam int unsigned U_DEPTH = (U_TOTAL < (1 << INDEX_W)) ? U_TOTAL : (1 << INDEX_W);
  localparam int unsigned U_AW    = (U_DEPTH > 1) ? $clog2(U_DEPTH) : 1;
  localparam int unsigned UOFF_W  = (U_TOTAL > 1) ? $clog2(U_TOTAL) : 1;
  localparam int unsigned V_DEPTH = MAX_BOND_DIM ** 3;
  localparam int unsigned V_AW    = (V_DEPTH > 1) ? $clog2(V_DEPTH) : 1;
  localparam int unsigned T_DEPTH = MAX_BOND_DIM * MAX_BOND_DIM;
  localparam int unsigned ACC_W   = PROD_W + ((T_DEPTH > 1) ? $clog2(T_DEPTH) : 0);

  // stores
  logic signed [VALUE_W-1:0] u_mem [U_DEPTH];
  logic signed [VALUE_W-1:0] v_mem [V_DEPTH];
  logic signed [POT_W-1:0]   t_mem [T_DEPTH];
  logic signed [VALUE_W-1:0] left_q  [MAX_BOND_DIM];
  logic signed [VALUE_W-1:0] right_q [MAX_BOND_DIM];

  logic [UOFF_W-1:0] u_off_q, u_base, u_raddr;
  logic [V_AW-1:0]   v_off_q, v_base, v_raddr;
  logic              we_u, we_v, we_left, we_right;

  logic signed [VALUE_W-1:0] u_rd_q, v_rd_q, opb;
  logic signed [POT_W-1:0]   t_rd_q;
  logic signed [LR_W-1:0]    lr_q, opa;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q, t_shift, o_shift;
  logic signed [POT_W-1:0]   t_sat, o_sat;
  pipe_t                     s1_q, s2_q, s3_q;
  logic [AB_W-1:0]           ab_s1_q, ab_s2_q, ab_s3_q;
  logic                      out_valid_q, t_we, o_we;

  // load decode
  always_comb begin
    we_u     = 1'b0;
    we_v     = 1'b0;
    we_left  = 1'b0;
    we_right = 1'b0;
    case (in_cmd_i)
      OP_WRITE_U:     we_u     = cmd_i.accept && (32'(in_index_i) < U_TOTAL);
      OP_WRITE_V:     we_v     = cmd_i.accept && (32'(in_index_i) < V_DEPTH);
      OP_WRITE_LEFT:  we_left  = cmd_i.accept && (32'(in_index_i) < MAX_BOND_DIM);
      OP_WRITE_RIGHT: we_right = cmd_i.accept && (32'(in_index_i) < MAX_BOND_DIM);
      default:        we_u     = 1'b0;
    endcase
  end

  // read addresses: running offsets step by chi squared (u) or chi (v)
  assign u_base  = cmd_i.first ? '0 : u_off_q;
  assign u_raddr = u_base + UOFF_W'(ab_i);
  assign v_base  = cmd_i.first ? '0 : v_off_q;
  assign v_raddr = v_base + V_AW'(i_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue && !cmd_i.phase2) u_off_q <= u_base + UOFF_W'(chi2_i);
    if (cmd_i.issue && cmd_i.phase2)  v_off_q <= v_base + V_AW'(chi_i);
  end

  // u store
  always_ff @(posedge clk_i) begin
    if (we_u) u_mem[in_index_i[U_AW-1:0]] <= in_value_i;
    u_rd_q <= u_mem[u_raddr[U_AW-1:0]];
  end

  // v store
  always_ff @(posedge clk_i) begin
    if (we_v) v_mem[in_index_i[V_AW-1:0]] <= in_value_i;
    v_rd_q <= v_mem[v_raddr];
  end

  // intermediate matrix
  always_ff @(posedge clk_i) begin
    if (t_we) t_mem[ab_s3_q] <= t_sat;
    t_rd_q <= t_mem[ab_i];
  end

  // left and right vectors, and their product
  always_ff @(posedge clk_i) begin
    if (we_left)  left_q[in_index_i[IDX_W-1:0]]  <= in_value_i;
    if (we_right) right_q[in_index_i[IDX_W-1:0]] <= in_value_i;
    lr_q <= left_q[c_i] * right_q[d_i];
  end

  // shared multiplier operands
  assign opa = s1_q.phase2 ? t_rd_q : lr_q;
  assign opb = s1_q.phase2 ? v_rd_q : u_rd_q;

  // multiply and accumulate
  always_ff @(posedge clk_i) begin
    prod_q  <= opa * opb;
    ab_s1_q <= ab_i;
    ab_s2_q <= ab_s1_q;
    ab_s3_q <= ab_s2_q;
    if (s2_q.vld) begin
      acc_q <= s2_q.first ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    end
  end

  // shift and saturate the finished sums
  assign t_shift = acc_q >>> T_SHIFT;
  assign o_shift = acc_q >>> OUT_SHIFT;

  always_comb begin
    if ((t_shift[ACC_W-1:POT_W-1] == '0) || (t_shift[ACC_W-1:POT_W-1] == '1)) begin
      t_sat = t_shift[POT_W-1:0];
    end else begin
      t_sat = t_shift[ACC_W-1] ? SAT_MIN : SAT_MAX;
    end
    if ((o_shift[ACC_W-1:POT_W-1] == '0) || (o_shift[ACC_W-1:POT_W-1] == '1)) begin
      o_sat = o_shift[POT_W-1:0];
    end else begin
      o_sat = o_shift[ACC_W-1] ? SAT_MIN : SAT_MAX;
    end
  end

  assign t_we = s3_q.vld && s3_q.last && !s3_q.phase2;
  assign o_we = s3_q.vld && s3_q.last && s3_q.phase2;

  // result payload
  always_ff @(posedge clk_i) begin
    if (o_we) begin
      out_potential_o <= o_sat;
      out_index_o     <= OUT_IDX_W'(i_i);
      out_last_o      <= cmd_i.final_item;
    end
  end

  // pipe flags and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      s2_q        <= '0;
      s3_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_q <= '{vld: cmd_i.issue, phase2: cmd_i.phase2, first: cmd_i.first,
                last: cmd_i.last};
      s2_q <= s1_q;
      s3_q <= s2_q;
      if (o_we) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.pipe_busy = s1_q.vld || s2_q.vld || s3_q.vld;
  assign status_o.out_busy  = out_valid_q;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_we |-> !out_valid_q)
    else $error("result landed on an occupied output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.issue && s1_q.vld) |-> (cmd_i.phase2 == s1_q.phase2))
    else $error("stages mixed in the mac pipe");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_q.vld && s2_q.vld) |-> (s1_q.phase2 == s2_q.phase2))
    else $error("intermediate matrix read before its last write");

endmodule

// ===== rtl/core/two_stage_tensor_contraction.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stage_tensor_contraction
// Load items fill the u, v, left and right stores, one item per cycle while idle.
// A start item runs chi^4 mac steps to build the intermediate matrix, drains
// the mac pipe, then per output position chi^2 mac steps and a wait until the
// result is taken; both stages share one mac multiplier.
// Reset clears control and sets bond_dim to 8; stores are not cleared.
// ----------------------------------------------------------------------------
module two_stage_tensor_contraction #(
  parameter int unsigned MAX_BOND_DIM = tsc_pkg::DEF_MAX_BOND_DIM
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tsc_pkg::BOND_DIM_W-1:0] cfg_wdata_i,
  tsc_in_if.sink                         in_i,
  tsc_out_if.source                      out_o
);
  import tsc_pkg::*;

  localparam int unsigned IDX_W  = (MAX_BOND_DIM > 1) ? $clog2(MAX_BOND_DIM) : 1;
  localparam int unsigned AB_W   = (MAX_BOND_DIM > 1) ? $clog2(MAX_BOND_DIM * MAX_BOND_DIM) : 1;
  localparam int unsigned CHI_W  = $clog2(MAX_BOND_DIM + 1);
  localparam int unsigned CHI2_W = $clog2(MAX_BOND_DIM * MAX_BOND_DIM + 1);

  ctrl_cmd_t          cmd;
  dp_status_t         status;
  logic [IDX_W-1:0]   c_idx, d_idx, i_idx;
  logic [AB_W-1:0]    ab_idx;
  logic [CHI_W-1:0]   chi;
  logic [CHI2_W-1:0]  chi2;

  // sequencer
  tsc_ctrl #(
    .MAX_BOND_DIM (MAX_BOND_DIM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.cmd),
    .in_ready_o  (in_i.ready),
    .status_i    (status),
    .cmd_o       (cmd),
    .c_o         (c_idx),
    .d_o         (d_idx),
    .ab_o        (ab_idx),
    .i_o         (i_idx),
    .chi_o       (chi),
    .chi2_o      (chi2)
  );

  // stores and arithmetic
  tsc_datapath #(
    .MAX_BOND_DIM (MAX_BOND_DIM)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_cmd_i        (in_i.cmd),
    .in_index_i      (in_i.index),
    .in_value_i      (in_i.value),
    .cmd_i           (cmd),
    .c_i             (c_idx),
    .d_i             (d_idx),
    .ab_i            (ab_idx),
    .i_i             (i_idx),
    .chi_i           (chi),
    .chi2_i          (chi2),
    .status_o        (status),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .out_potential_o (out_o.potential),
    .out_index_o     (out_o.out_index),
    .out_last_o      (out_o.last)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two stage tensor contraction. Load and start
// items go in over the input channel with random gaps; every accepted item
// also updates a local contraction model, which queues the potentials that
// each start must produce. The output side takes potentials with random stalls
// (one long hold included) and compares them field by field, in order.
// A directed table at chi 1 comes first, then random phases over bond
// dimension settings up to four, the zero setting included.
// ----------------------------------------------------------------------------
module tb_top;
  import tsc_pkg::*;

  localparam int MAX_CHI = DEF_MAX_BOND_DIM;
  localparam int U_SIZE  = MAX_CHI * MAX_CHI * MAX_CHI * MAX_CHI;
  localparam int V_SIZE  = MAX_CHI * MAX_CHI * MAX_CHI;
  localparam int T_SIZE  = MAX_CHI * MAX_CHI;

  // commands the block has no meaning for
  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;

  localparam int STALL_LIMIT      = 20000;
  localparam int HOLD_CYCLES      = 600;
  localparam int HOLD_AFTER_START = 5;
  localparam int SETTLE_CYCLES    = 32;
  localparam int DRAIN_CYCLES     = 64;
  localparam int PRINT_LIMIT      = 100;

  typedef struct {
    logic signed [POT_W-1:0]     potential;
    logic        [OUT_IDX_W-1:0] out_index;
    logic                        last;
  } potential_t;

  typedef struct {
    logic [CMD_W-1:0] op;
    int               idx;
    int               val;
    bit               typed;
    int               pot;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [BOND_DIM_W-1:0] cfg_wdata_i;

  tsc_in_if  in_ch ();
  tsc_out_if out_ch ();

  two_stage_tensor_contraction i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // local copy of the stores, the intermediate matrix and the register
  bit signed [VALUE_W-1:0] u_tensor  [U_SIZE];
  bit signed [VALUE_W-1:0] v_tensor  [V_SIZE];
  bit signed [VALUE_W-1:0] left_vec  [MAX_CHI];
  bit signed [VALUE_W-1:0] right_vec [MAX_CHI];
  bit signed [POT_W-1:0]   t_matrix  [T_SIZE];
  bit                      u_loaded  [U_SIZE];
  bit                      v_loaded  [V_SIZE];
  bit                      left_loaded  [MAX_CHI];
  bit                      right_loaded [MAX_CHI];
  logic [BOND_DIM_W-1:0]   bond_dim_cfg = BOND_DIM_RST;

  potential_t expected_potentials [$];
  int         mismatch_count;
  int         src_quiet;
  bit         hold_request;

  // directed items at chi 1; starts carry the potential worked out by hand
  stim_row_t directed_rows [22] = '{
    '{OP_WRITE_LEFT,  0,    -32768, 1'b0, 0},
    '{OP_WRITE_RIGHT, 0,    -32768, 1'b0, 0},
    '{OP_WRITE_U,     0,    -32768, 1'b0, 0},
    '{OP_WRITE_V,     0,    -32768, 1'b0, 0},
    '{OP_START,       0,    0,      1'b1, 32768},
    '{OP_WRITE_V,     0,    32767,  1'b0, 0},
    '{OP_START,       0,    0,      1'b1, -32767},
    '{OP_WRITE_U,     0,    32767,  1'b0, 0},
    '{OP_START,       0,    0,      1'b1, 32766},
    '{OP_WRITE_RIGHT, 0,    1,      1'b0, 0},
    '{OP_WRITE_U,     0,    1,      1'b0, 0},
    // both shifts round toward minus infinity
    '{OP_START,       0,    0,      1'b1, -1},
    // writes past the end of a store must not alias onto entry zero
    '{OP_WRITE_V,     4095, 0,      1'b0, 0},
    '{OP_WRITE_V,     512,  0,      1'b0, 0},
    '{OP_WRITE_LEFT,  8,    0,      1'b0, 0},
    '{OP_WRITE_RIGHT, 4095, 0,      1'b0, 0},
    // unknown commands do nothing
    '{CMD_RSVD5,      4095, 32767,  1'b0, 0},
    '{CMD_RSVD6,      1234, -5,     1'b0, 0},
    '{CMD_RSVD7,      0,    -32768, 1'b0, 0},
    '{OP_START,       0,    0,      1'b1, -1},
    '{OP_WRITE_U,     4095, -32768, 1'b0, 0},
    '{OP_START,       4095, -1,     1'b1, -1}
  };

  // bond dimension per random phase, and items per phase; chi stays at four
  // or below so the tensor fills stay short
  int phase_bond  [14] = '{2, 3, 0, 4, 1, 3, 2, 4, 3, 1, 2, 4, 0, 3};
  int phase_items [14] = '{6, 6, 4, 8, 4, 6, 6, 8, 6, 4, 6, 8, 4, 14};

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // random gap before the next item, with quiet stretches of back to back items
  function automatic int draw_gap(ref int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  function automatic int pick_value();
    case ($urandom_range(0, 15))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int unsigned chi_in_force();
    if (bond_dim_cfg == 0) return 1;
    if (bond_dim_cfg > MAX_CHI) return MAX_CHI;
    return bond_dim_cfg;
  endfunction

  function automatic logic signed [POT_W-1:0] saturate(input longint x);
    if (x > longint'(SAT_MAX)) return SAT_MAX;
    if (x < longint'(SAT_MIN)) return SAT_MIN;
    return x[POT_W-1:0];
  endfunction

  // contraction model: apply one accepted item, queue the potentials of a start
  task automatic predict_item(input logic [CMD_W-1:0] op, input logic [INDEX_W-1:0] idx,
                              input logic signed [VALUE_W-1:0] val, input bit typed,
                              input int typed_pot);
    int unsigned chi, a, b, c, d, i, ab;
    longint      acc;
    potential_t  res;
    chi = chi_in_force();
    case (op)
      OP_WRITE_U: begin
        if (idx < U_SIZE) begin
          u_tensor[idx] = val;
          u_loaded[idx] = 1'b1;
        end
      end
      OP_WRITE_V: begin
        if (idx < V_SIZE) begin
          v_tensor[idx] = val;
          v_loaded[idx] = 1'b1;
        end
      end
      OP_WRITE_LEFT: begin
        if (idx < MAX_CHI) begin
          left_vec[idx]    = val;
          left_loaded[idx] = 1'b1;
        end
      end
      OP_WRITE_RIGHT: begin
        if (idx < MAX_CHI) begin
          right_vec[idx]    = val;
          right_loaded[idx] = 1'b1;
        end
      end
      OP_START: begin
        // disentangler stage: T[a][b] from left, right and U
        for (a = 0; a < chi; a++) begin
          for (b = 0; b < chi; b++) begin
            acc = 0;
            for (c = 0; c < chi; c++) begin
              for (d = 0; d < chi; d++) begin
                acc += longint'(left_vec[c]) * longint'(right_vec[d])
                       * longint'(u_tensor[((c * chi + d) * chi + a) * chi + b]);
              end
            end
            t_matrix[a * chi + b] = saturate(acc >>> T_SHIFT);
          end
        end
        // isometry stage: one potential per output position
        for (i = 0; i < chi; i++) begin
          acc = 0;
          for (a = 0; a < chi; a++) begin
            for (b = 0; b < chi; b++) begin
              ab = a * chi + b;
              acc += longint'(t_matrix[ab]) * longint'(v_tensor[ab * chi + i]);
            end
          end
          res.potential = typed ? typed_pot : saturate(acc >>> OUT_SHIFT);
          res.out_index = i[OUT_IDX_W-1:0];
          res.last      = (i == chi - 1);
          expected_potentials.push_back(res);
        end
      end
      default: ;
    endcase
  endtask

  // offer one item after a random gap and hold it until accepted
  task automatic send_item(input logic [CMD_W-1:0] op, input int idx, input int val,
                           input bit typed, input int typed_pot);
    int gap;
    gap = draw_gap(src_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= op;
    in_ch.index <= idx[INDEX_W-1:0];
    in_ch.value <= val[VALUE_W-1:0];
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    predict_item(op, idx[INDEX_W-1:0], val[VALUE_W-1:0], typed, typed_pot);
  endtask

  task automatic write_bond_dim(input logic [BOND_DIM_W-1:0] dim);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= dim;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    bond_dim_cfg  = dim;
  endtask

  // wait until every queued potential has come, then let loads finish
  task automatic settle(input int cycles);
    in_ch.valid <= 1'b0;
    while (expected_potentials.size() > 0) @(posedge clk_i);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("tb_top: mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_potential(input logic signed [POT_W-1:0] pot,
                                 input logic [OUT_IDX_W-1:0] idx, input logic lst);
    potential_t want;
    if (expected_potentials.size() == 0) begin
      report_mismatch($sformatf("unexpected potential %0d at position %0d", pot, idx));
    end else begin
      want = expected_potentials.pop_front();
      if (pot !== want.potential)
        report_mismatch($sformatf("potential %0d, expected %0d (position %0d)",
                                  pot, want.potential, want.out_index));
      if (idx !== want.out_index)
        report_mismatch($sformatf("out_index %0d, expected %0d", idx, want.out_index));
      if (lst !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b (position %0d)",
                                  lst, want.last, want.out_index));
    end
  endtask

  // stimulus: reset, directed table, then random phases
  initial begin : stimulus
    int unsigned chi, u_span, v_span, span, e;
    int          k, roll, starts_sent;
    bit          hold_done;
    logic [CMD_W-1:0] op;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.cmd      <= OP_WRITE_U;
    in_ch.index    <= '0;
    in_ch.value    <= '0;
    starts_sent     = 0;
    hold_done       = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_bond_dim(4'd1);
    foreach (directed_rows[r])
      send_item(directed_rows[r].op, directed_rows[r].idx, directed_rows[r].val,
                directed_rows[r].typed, directed_rows[r].pot);

    foreach (phase_bond[p]) begin
      settle(SETTLE_CYCLES);
      write_bond_dim(phase_bond[p][BOND_DIM_W-1:0]);
      chi    = chi_in_force();
      v_span = chi * chi * chi;
      u_span = v_span * chi;
      for (k = 0; k < phase_items[p]; k++) begin
        roll = $urandom_range(0, 99);
        if (k == phase_items[p] - 1 || k == phase_items[p] / 2 || roll < 12) begin
          // give a value to every entry this chi reads that has none yet
          for (e = 0; e < u_span; e++)
            if (!u_loaded[e]) send_item(OP_WRITE_U, e, pick_value(), 1'b0, 0);
          for (e = 0; e < v_span; e++)
            if (!v_loaded[e]) send_item(OP_WRITE_V, e, pick_value(), 1'b0, 0);
          for (e = 0; e < chi; e++) begin
            if (!left_loaded[e]) send_item(OP_WRITE_LEFT, e, pick_value(), 1'b0, 0);
            if (!right_loaded[e]) send_item(OP_WRITE_RIGHT, e, pick_value(), 1'b0, 0);
          end
          send_item(OP_START, $urandom_range(0, 4095), pick_value(), 1'b0, 0);
          starts_sent++;
          // output side stalls for a long while and more items follow, so the
          // block backs up
          if (!hold_done && starts_sent >= HOLD_AFTER_START && k < phase_items[p] - 1) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
          end
        end else if (roll < 22) begin
          // noise: unknown commands and writes past a store
          case ($urandom_range(0, 2))
            0: send_item(CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7)),
                         $urandom_range(0, 4095), pick_value(), 1'b0, 0);
            1: send_item(OP_WRITE_V, $urandom_range(V_SIZE, 4095), pick_value(), 1'b0, 0);
            default: send_item($urandom_range(0, 1) ? OP_WRITE_LEFT : OP_WRITE_RIGHT,
                               $urandom_range(MAX_CHI, 4095), pick_value(), 1'b0, 0);
          endcase
        end else begin
          // load inside the part of the store that this chi uses, at times anywhere in the index range
          op = CMD_W'($urandom_range(OP_WRITE_U, OP_WRITE_RIGHT));
          case (op)
            OP_WRITE_U: span = u_span;
            OP_WRITE_V: span = v_span;
            default:    span = chi;
          endcase
          if ($urandom_range(0, 7) == 0) span = 4096;
          send_item(op, $urandom_range(0, span - 1), pick_value(), 1'b0, 0);
        end
      end
    end

    settle(DRAIN_CYCLES);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // output side: random stall per item, one long hold on request
  initial begin : potential_sink
    int wait_left, hold_left, quiet;
    wait_left = 0;
    hold_left = 0;
    quiet     = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        check_potential(out_ch.potential, out_ch.out_index, out_ch.last);
        wait_left = draw_gap(quiet);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog: too long with no item moving on either channel
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("tb_top: timeout, no item moved for %0d cycles", STALL_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
